@@ src/mrc_pkg.sv @@
// Shared types and constants for the memory region coalescer.
// Holds the region kind codes, the type-code lookup and the queue/result records.
// No dependencies.
package mrc_pkg;

   // Region kind codes
   localparam logic [2:0] KIND_RESERVED   = 3'd0;
   localparam logic [2:0] KIND_UNUSABLE   = 3'd1;
   localparam logic [2:0] KIND_ACPI       = 3'd2;
   localparam logic [2:0] KIND_RAM        = 3'd3;
   localparam logic [2:0] KIND_NVS        = 3'd4;
   localparam logic [2:0] KIND_PERSISTENT = 3'd5;

   // Result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_TYPE = 1'b1;

   // Firmware type codes at or above this value are unknown
   localparam logic [31:0] TYPE_CODE_LIMIT = 32'd15;

   // Region ordinal saturates here
   localparam logic [15:0] INDEX_MAX = 16'hFFFF;

   // One classified descriptor as it travels from front to back
   typedef struct packed {
      logic        invalid;
      logic [2:0]  kind;
      logic [63:0] start;
      logic [63:0] bytes;
      logic [63:0] stop;   // start + bytes, modulo 2^64
      logic        last;
   } desc_type;

   // One result beat
   typedef struct packed {
      logic [63:0] address;
      logic [63:0] size;
      logic [2:0]  kind;
      logic [15:0] index;
      logic        status;
      logic        final_flag;
   } region_type;

   // Map a valid UEFI type code (0..14) onto a region kind
   function automatic logic [2:0] kind_of_code(input logic [3:0] code);
      logic [2:0] k;
      case (code)
         4'd1, 4'd2, 4'd3, 4'd4, 4'd7: k = KIND_RAM;
         4'd8:                         k = KIND_UNUSABLE;
         4'd9:                         k = KIND_ACPI;
         4'd10:                        k = KIND_NVS;
         4'd14:                        k = KIND_PERSISTENT;
         default:                      k = KIND_RESERVED;
      endcase
      return k;
   endfunction

endpackage

@@ src/mrc_front.sv @@
// Front end of the coalescer: classifies a descriptor and sizes it.
// Produces the record pushed into the decoupling queue. Depends on mrc_pkg.
module mrc_front #(
   parameter int PAGE_SHIFT = 12
) (
   input  logic [31:0]        desc_code,
   input  logic [63:0]        phys_start,
   input  logic [51:0]        page_count,
   input  logic               last_desc,
   output mrc_pkg::desc_type  item
);
   import mrc_pkg::*;

   logic [63:0] bytes;

   // Convert pages to bytes, wrapping at 64 bits
   assign bytes = 64'(page_count) << PAGE_SHIFT;

   // Classify the type code and precompute the region end
   always_comb begin
      item.invalid = (desc_code >= TYPE_CODE_LIMIT);
      item.kind    = kind_of_code(desc_code[3:0]);
      item.start   = phys_start;
      item.bytes   = bytes;
      item.stop    = phys_start + bytes;
      item.last    = last_desc;
   end

endmodule

@@ src/mrc_queue.sv @@
// Two-entry queue that decouples the front end from the merge stage.
// Depends on mrc_pkg.
module mrc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mrc_pkg::desc_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mrc_pkg::desc_type  head_item
);
   import mrc_pkg::*;

   desc_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed beats
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/mrc_back.sv @@
// Merge stage of the coalescer: holds the open region, merges or displaces,
// and queues up to two result beats per descriptor. Depends on mrc_pkg.
module mrc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  mrc_pkg::desc_type   head_item,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output mrc_pkg::region_type out_beat
);
   import mrc_pkg::*;

   // Held region
   logic        held_valid_ff, held_valid_in;
   logic [63:0] held_addr_ff, held_addr_in;
   logic [63:0] held_size_ff, held_size_in;
   logic [63:0] held_end_ff, held_end_in;
   logic [2:0]  held_kind_ff, held_kind_in;
   logic [15:0] counter_ff, counter_in;

   // Result buffer
   region_type  out_mem_ff [4];
   logic [1:0]  out_wr_ff, out_wr_in;
   logic [1:0]  out_rd_ff, out_rd_in;
   logic [2:0]  out_cnt_ff, out_cnt_in;

   logic        merge;
   logic        displace;
   logic [15:0] counter_inc;
   logic [15:0] counter_after;
   logic [63:0] new_addr;
   logic [63:0] new_size;
   region_type  beat0;
   region_type  beat1;
   logic [1:0]  push_n;
   logic        out_pop;

   // Take the next descriptor only when two result slots are free
   assign pop       = head_valid && (out_cnt_ff <= 3'd2);
   assign out_valid = (out_cnt_ff != 3'd0);
   assign out_pop   = out_valid && out_ready;
   assign out_beat  = out_mem_ff[out_rd_ff];

   // Decide merge versus displace and build the result beats
   always_comb begin
      merge = held_valid_ff && (held_kind_ff == head_item.kind)
              && (held_end_ff == head_item.start);
      displace    = !head_item.invalid && held_valid_ff && !merge;
      counter_inc = (counter_ff == INDEX_MAX) ? counter_ff : counter_ff + 16'd1;
      counter_after = displace ? counter_inc : counter_ff;
      new_addr = merge ? held_addr_ff : head_item.start;
      new_size = merge ? held_size_ff + head_item.bytes : head_item.bytes;

      beat0 = '0;
      beat1 = '0;
      push_n = 2'd0;
      if (head_item.invalid) begin
         beat0.kind       = KIND_RESERVED;
         beat0.status     = STATUS_BAD_TYPE;
         beat0.final_flag = head_item.last;
         push_n = 2'd1;
      end else if (displace) begin
         beat0 = '{held_addr_ff, held_size_ff, held_kind_ff, counter_ff,
                   STATUS_OK, 1'b0};
         beat1 = '{new_addr, new_size, head_item.kind, counter_after,
                   STATUS_OK, 1'b1};
         push_n = head_item.last ? 2'd2 : 2'd1;
      end else begin
         beat0 = '{new_addr, new_size, head_item.kind, counter_after,
                   STATUS_OK, 1'b1};
         push_n = head_item.last ? 2'd1 : 2'd0;
      end
      if (!pop) begin
         push_n = 2'd0;
      end
   end

   // Update the held region
   always_comb begin
      held_valid_in = held_valid_ff;
      held_addr_in  = held_addr_ff;
      held_size_in  = held_size_ff;
      held_end_in   = held_end_ff;
      held_kind_in  = held_kind_ff;
      counter_in    = counter_ff;
      if (pop) begin
         if (head_item.invalid || head_item.last) begin
            held_valid_in = 1'b0;
            counter_in    = 16'd0;
         end else begin
            held_valid_in = 1'b1;
            held_addr_in  = new_addr;
            held_size_in  = new_size;
            held_end_in   = head_item.stop;
            held_kind_in  = head_item.kind;
            counter_in    = counter_after;
         end
      end
   end

   // Advance result buffer pointers
   always_comb begin
      out_wr_in  = out_wr_ff + push_n;
      out_rd_in  = out_rd_ff + 2'(out_pop);
      out_cnt_in = out_cnt_ff + 3'(push_n) - 3'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         counter_ff    <= 16'd0;
         out_wr_ff     <= 2'd0;
         out_rd_ff     <= 2'd0;
         out_cnt_ff    <= 3'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         counter_ff    <= counter_in;
         out_wr_ff     <= out_wr_in;
         out_rd_ff     <= out_rd_in;
         out_cnt_ff    <= out_cnt_in;
      end
   end

   // Hold region payload; only meaningful while held_valid_ff is set
   always_ff @(posedge clock) begin
      held_addr_ff <= held_addr_in;
      held_size_ff <= held_size_in;
      held_end_ff  <= held_end_in;
      held_kind_ff <= held_kind_in;
   end

   // Write result beats into the buffer
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         out_mem_ff[out_wr_ff] <= beat0;
      end
      if (push_n == 2'd2) begin
         out_mem_ff[out_wr_ff + 2'd1] <= beat1;
      end
   end

endmodule

@@ src/memory_region_coalescer_top.sv @@
// Top level of the memory region coalescer: front end, queue and merge stage.
// Depends on mrc_pkg, mrc_front, mrc_queue and mrc_back.
//
//   Channel | Ports          | Direction | Moves
//   req     | req_valid/ready | in       | one firmware descriptor per beat
//   rsp     | rsp_valid/ready | out      | one region or error per beat
//
// A descriptor enters the two-entry queue when it is accepted and is merged
// from the queue head; its results are registered in the result buffer.
// Sustained rate is one descriptor per cycle while each yields at most one
// result and the result port is ready; a descriptor that yields two puts two
// beats on the result port. The merge stage takes a descriptor only while the
// four-entry result buffer has two free slots. Reset is synchronous and empties
// the queue, the buffer and the held region.
module memory_region_coalescer_top #(
   parameter int PAGE_SHIFT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_desc_type,
   input  logic [63:0] req_phys_start,
   input  logic [51:0] req_page_count,
   input  logic        req_last_desc,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_region_address,
   output logic [63:0] rsp_region_size,
   output logic [2:0]  rsp_region_kind,
   output logic [15:0] rsp_region_index,
   output logic        rsp_status_code,
   output logic        rsp_final_result
);
   import mrc_pkg::*;

   desc_type   front_item;
   desc_type   head_item;
   region_type out_beat;
   logic       queue_full;
   logic       head_valid;
   logic       pop;
   logic       push;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   mrc_front #(
      .PAGE_SHIFT(PAGE_SHIFT)
   ) u_front (
      .desc_code  (req_desc_type),
      .phys_start (req_phys_start),
      .page_count (req_page_count),
      .last_desc  (req_last_desc),
      .item       (front_item)
   );

   mrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_beat   (out_beat)
   );

   // Unpack the result beat onto the ports
   assign rsp_region_address = out_beat.address;
   assign rsp_region_size    = out_beat.size;
   assign rsp_region_kind    = out_beat.kind;
   assign rsp_region_index   = out_beat.index;
   assign rsp_status_code    = out_beat.status;
   assign rsp_final_result   = out_beat.final_flag;

endmodule

@@ tb/region_map_checker.sv @@
// Scoreboard for the memory region coalescer: predicts the region map from the
// descriptor beats it sees and compares every result beat in order.
// Depends on mrc_pkg for the kind, status, type-code limit and index constants.
`timescale 1ns / 1ps

module region_map_checker #(
   parameter int PAGE_SHIFT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_desc_type,
   input  logic [63:0] req_phys_start,
   input  logic [51:0] req_page_count,
   input  logic        req_last_desc,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_region_address,
   input  logic [63:0] rsp_region_size,
   input  logic [2:0]  rsp_region_kind,
   input  logic [15:0] rsp_region_index,
   input  logic        rsp_status_code,
   input  logic        rsp_final_result,
   output int          fail_count,
   output int          pending_count,
   output int          descs_seen,
   output int          regions_seen,
   output int          merges_seen,
   output int          bad_types_seen,
   output int          saturated_seen
);

   // Firmware memory type codes
   localparam logic [3:0] EFI_RESERVED       = 4'd0;
   localparam logic [3:0] EFI_LOADER_CODE    = 4'd1;
   localparam logic [3:0] EFI_LOADER_DATA    = 4'd2;
   localparam logic [3:0] EFI_BOOT_CODE      = 4'd3;
   localparam logic [3:0] EFI_BOOT_DATA      = 4'd4;
   localparam logic [3:0] EFI_RUNTIME_CODE   = 4'd5;
   localparam logic [3:0] EFI_RUNTIME_DATA   = 4'd6;
   localparam logic [3:0] EFI_CONVENTIONAL   = 4'd7;
   localparam logic [3:0] EFI_UNUSABLE       = 4'd8;
   localparam logic [3:0] EFI_ACPI_RECLAIM   = 4'd9;
   localparam logic [3:0] EFI_ACPI_NVS       = 4'd10;
   localparam logic [3:0] EFI_MMIO           = 4'd11;
   localparam logic [3:0] EFI_MMIO_PORT      = 4'd12;
   localparam logic [3:0] EFI_PAL_CODE       = 4'd13;
   localparam logic [3:0] EFI_PERSISTENT     = 4'd14;

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [63:0] addr;
      logic [63:0] bytes;
      logic [2:0]  kind;
      logic [15:0] index;
      logic        status;
      logic        closes_map;
   } region_rec_type;

   region_rec_type awaited_regions[$];

   // Region currently being grown
   logic        held_live;
   logic [63:0] held_base;
   logic [63:0] held_bytes;
   logic [2:0]  held_kind;
   logic [15:0] next_index;

   initial begin
      fail_count     = 0;
      pending_count  = 0;
      descs_seen     = 0;
      regions_seen   = 0;
      merges_seen    = 0;
      bad_types_seen = 0;
      saturated_seen = 0;
   end

   function automatic logic [2:0] kind_for_code(input logic [3:0] code);
      case (code)
         EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BOOT_CODE, EFI_BOOT_DATA,
         EFI_CONVENTIONAL: return mrc_pkg::KIND_RAM;
         EFI_UNUSABLE:     return mrc_pkg::KIND_UNUSABLE;
         EFI_ACPI_RECLAIM: return mrc_pkg::KIND_ACPI;
         EFI_ACPI_NVS:     return mrc_pkg::KIND_NVS;
         EFI_PERSISTENT:   return mrc_pkg::KIND_PERSISTENT;
         EFI_RESERVED, EFI_RUNTIME_CODE, EFI_RUNTIME_DATA, EFI_MMIO,
         EFI_MMIO_PORT, EFI_PAL_CODE: return mrc_pkg::KIND_RESERVED;
         default:          return mrc_pkg::KIND_RESERVED;
      endcase
   endfunction

   // Start a fresh map
   task automatic clear_map();
      held_live  = 1'b0;
      held_base  = '0;
      held_bytes = '0;
      held_kind  = mrc_pkg::KIND_RESERVED;
      next_index = '0;
   endtask

   // Queue the held region as the next expected beat; the ordinal saturates
   task automatic emit_held(input logic closes_map);
      region_rec_type rec;
      rec.addr       = held_base;
      rec.bytes      = held_bytes;
      rec.kind       = held_kind;
      rec.index      = next_index;
      rec.status     = mrc_pkg::STATUS_OK;
      rec.closes_map = closes_map;
      awaited_regions.push_back(rec);
      if (next_index != mrc_pkg::INDEX_MAX) next_index++;
   endtask

   // Fold one descriptor into the map and queue whatever it produces
   task automatic coalesce_desc(input logic [31:0] code, input logic [63:0] start,
                                input logic [51:0] pages, input logic last);
      region_rec_type rec;
      logic [2:0]  kind;
      logic [63:0] bytes;
      if (code >= mrc_pkg::TYPE_CODE_LIMIT) begin
         // Unknown type aborts the map without emitting the held region
         rec.addr       = '0;
         rec.bytes      = '0;
         rec.kind       = mrc_pkg::KIND_RESERVED;
         rec.index      = '0;
         rec.status     = mrc_pkg::STATUS_BAD_TYPE;
         rec.closes_map = last;
         awaited_regions.push_back(rec);
         bad_types_seen++;
         clear_map();
         return;
      end
      kind  = kind_for_code(code[3:0]);
      bytes = 64'(pages) << PAGE_SHIFT;
      if (held_live && held_kind == kind && held_base + held_bytes == start) begin
         held_bytes = held_bytes + bytes;
         merges_seen++;
      end else begin
         if (held_live) emit_held(1'b0);
         held_live  = 1'b1;
         held_base  = start;
         held_bytes = bytes;
         held_kind  = kind;
      end
      if (last) begin
         emit_held(1'b1);
         clear_map();
      end
   endtask

   // Compare result beats first, then predict from the descriptor beat
   always @(posedge clock) begin : watch
      region_rec_type want;
      if (reset) begin
         clear_map();
         awaited_regions.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            regions_seen++;
            if (rsp_status_code === mrc_pkg::STATUS_OK &&
                rsp_region_index === mrc_pkg::INDEX_MAX) saturated_seen++;
            if (awaited_regions.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result beat", $time);
                  $display("   got  addr=%h size=%h kind=%0d idx=%0d st=%0d fin=%0d",
                           rsp_region_address, rsp_region_size, rsp_region_kind,
                           rsp_region_index, rsp_status_code, rsp_final_result);
               end
            end else begin
               want = awaited_regions.pop_front();
               if (rsp_region_address !== want.addr || rsp_region_size !== want.bytes ||
                   rsp_region_kind !== want.kind || rsp_region_index !== want.index ||
                   rsp_status_code !== want.status ||
                   rsp_final_result !== want.closes_map) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $time);
                     $display("   want addr=%h size=%h kind=%0d idx=%0d st=%0d fin=%0d",
                              want.addr, want.bytes, want.kind, want.index,
                              want.status, want.closes_map);
                     $display("   got  addr=%h size=%h kind=%0d idx=%0d st=%0d fin=%0d",
                              rsp_region_address, rsp_region_size, rsp_region_kind,
                              rsp_region_index, rsp_status_code, rsp_final_result);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            descs_seen++;
            coalesce_desc(req_desc_type, req_phys_start, req_page_count, req_last_desc);
         end
      end
      pending_count = awaited_regions.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Stimulus and verdict for the memory region coalescer: drives descriptor maps,
// throttles the result port and reports. Depends on mrc_pkg, the coalescer RTL
// and region_map_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int          PAGE_SHIFT  = 12;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          RANDOM_DESCS = 1350;
   localparam logic [31:0] TOP_CODE    = mrc_pkg::TYPE_CODE_LIMIT - 1;
   localparam logic [51:0] ALL_PAGES   = {52{1'b1}};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_desc_type;
   logic [63:0] req_phys_start;
   logic [51:0] req_page_count;
   logic        req_last_desc;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_region_address;
   logic [63:0] rsp_region_size;
   logic [2:0]  rsp_region_kind;
   logic [15:0] rsp_region_index;
   logic        rsp_status_code;
   logic        rsp_final_result;

   int fail_count;
   int pending_count;
   int descs_seen;
   int regions_seen;
   int merges_seen;
   int bad_types_seen;
   int saturated_seen;

   int cycle_count = 0;
   int sent = 0;
   bit steady = 1'b0;

   memory_region_coalescer_top #(.PAGE_SHIFT(PAGE_SHIFT)) dut (.*);

   region_map_checker #(.PAGE_SHIFT(PAGE_SHIFT)) scoreboard (.*);

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("memory_region_coalescer_top verification failed");
         $finish;
      end
   end

   // Stall the result port at random, with a chance of 13 in 100, outside steady stretches
   always @(negedge clock) begin
      if (steady) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 99) >= 13);
   end

   function automatic logic [63:0] random_addr();
      int unsigned pick;
      logic [63:0] raw;
      pick = $urandom_range(0, 99);
      raw  = {$urandom, $urandom};
      if (pick < 30) return raw;
      if (pick < 80) return {raw[63:12], 12'h000};
      // near the top of the space so region ends wrap
      return {40'hFF_FFFF_FFFF, raw[23:12], 12'h000};
   endfunction

   function automatic logic [51:0] random_pages();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 52'($urandom_range(0, 16));
      if (pick < 85) return 52'($urandom_range(0, 65535));
      return {20'($urandom), $urandom};
   endfunction

   // Present one descriptor beat and hold it until accepted; returns at a falling edge
   task automatic send_desc(input logic [31:0] code, input logic [63:0] start,
                            input logic [51:0] pages, input logic last);
      while (!steady && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_desc_type  <= code;
      req_phys_start <= start;
      req_page_count <= pages;
      req_last_desc  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // One map: mostly contiguous runs that may merge, some jumps and bad types
   task automatic send_map(input int unsigned length);
      logic [31:0] code;
      logic [63:0] start;
      logic [51:0] pages;
      logic [63:0] next_start;
      int unsigned pick;
      int unsigned k;
      code       = $urandom_range(0, mrc_pkg::TYPE_CODE_LIMIT - 1);
      next_start = random_addr();
      for (k = 0; k < length; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            start = next_start;
         end else if (pick < 65) begin
            code  = $urandom_range(0, mrc_pkg::TYPE_CODE_LIMIT - 1);
            start = next_start;
         end else if (pick < 78) begin
            start = random_addr();
         end else if (pick < 94) begin
            code  = $urandom_range(0, mrc_pkg::TYPE_CODE_LIMIT - 1);
            start = random_addr();
         end else begin
            code  = $urandom_range(0, 1) ? $urandom_range(mrc_pkg::TYPE_CODE_LIMIT, 255)
                                         : $urandom_range(mrc_pkg::TYPE_CODE_LIMIT,
                                                          32'hFFFF_FFFF);
            start = random_addr();
         end
         pages = random_pages();
         send_desc(code, start, pages, k == length - 1);
         next_start = start + (64'(pages) << PAGE_SHIFT);
         if (code >= mrc_pkg::TYPE_CODE_LIMIT)
            code = $urandom_range(0, mrc_pkg::TYPE_CODE_LIMIT - 1);
      end
   endtask

   // Block until every queued result beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [63:0] cursor;
      int unsigned c;
      bit paused;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_desc_type  = '0;
      req_phys_start = '0;
      req_page_count = '0;
      req_last_desc  = 1'b0;
      paused         = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every valid code in order on contiguous addresses; code 0 has no pages
      cursor = '0;
      for (c = 0; c < mrc_pkg::TYPE_CODE_LIMIT; c++) begin
         send_desc(c, cursor, 52'(c), 1'b0);
         cursor = cursor + (64'(c) << PAGE_SHIFT);
      end
      // Largest page count, then a merge past the wrapped end and a flush
      send_desc(TOP_CODE, cursor, ALL_PAGES, 1'b0);
      cursor = cursor + (64'(ALL_PAGES) << PAGE_SHIFT);
      send_desc(TOP_CODE, cursor, 52'd1, 1'b1);
      // Lowest unknown code with nothing held
      send_desc(mrc_pkg::TYPE_CODE_LIMIT, '1, ALL_PAGES, 1'b0);
      // Region ending exactly at the top of the space merges with one at zero
      send_desc(TOP_CODE, 64'hFFFF_FFFF_FFFF_F000, 52'd1, 1'b0);
      send_desc(TOP_CODE, '0, 52'd2, 1'b0);
      // Unknown code discards the held region and closes the map
      send_desc('1, 64'h0000_0000_0000_1000, 52'd3, 1'b1);
      // One-descriptor map, reserved, zero pages at the last address
      send_desc('0, '1, '0, 1'b1);
      // Contiguous but different kind: displaced region and flushed region together
      send_desc(TOP_CODE, '0, 52'd1, 1'b0);
      send_desc('0, 64'h0000_0000_0000_1000, 52'd1, 1'b1);
      send_desc(mrc_pkg::TYPE_CODE_LIMIT | 32'h8000_0000, '0, '0, 1'b1);

      // Random maps with one steady stretch and one full drain
      while (sent < RANDOM_DESCS) begin
         steady = (sent >= 420 && sent < 580);
         if (!paused && sent >= 800) begin
            drain();
            paused = 1'b1;
         end
         send_map($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 12));
      end
      steady = 1'b0;

      // A few closing maps after the random run
      repeat (4) send_map($urandom_range(2, 8));

      drain();
      repeat (16) @(posedge clock);

      $display("Run covered %0d descriptors and %0d result beats (%0d merges, %0d bad types).",
               descs_seen, regions_seen, merges_seen, bad_types_seen);
      $display("Saturated ordinals seen: %0d; mismatches: %0d.", saturated_seen, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("memory_region_coalescer_top verification clean");
      else
         $display("memory_region_coalescer_top verification failed");
      $finish;
   end

endmodule
